// File: hdl/ldq_pkg.sv
// ldq_pkg: shared types and constants for the linear double-ended queue.
// Used by ldq_ctrl and linear_double_ended_queue; depends on nothing.
package ldq_pkg;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int DATA_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;
    localparam int CAP_W  = 4;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Byte returned when nothing is popped (ASCII space)
    localparam logic [DATA_W-1:0] SPACE_BYTE = 8'd32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Result information carried alongside the slot read
    typedef struct packed {
        logic             rd_hit;    // a slot was read, data comes from the RAM
        status_t          status;
        logic [OCC_W-1:0] occupancy;
    } step_info_t;

endpackage

// File: hdl/ldq_ram.sv
// ldq_ram: generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module ldq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the last word when no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ldq_ctrl.sv
// ldq_ctrl: front/rear index registers, capacity register and the per-request
// decision logic that drives the slot RAM. Depends on ldq_pkg.
module ldq_ctrl #(
    parameter int DEPTH = 8,
    localparam int IDX_W = $clog2(DEPTH + 1),
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [ldq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         accept,
    input  logic [ldq_pkg::OP_W-1:0]     operation,
    input  logic [ldq_pkg::DATA_W-1:0]   data_in,
    output logic                         mem_wr_en,
    output logic [AW-1:0]                mem_wr_addr,
    output logic [ldq_pkg::DATA_W-1:0]   mem_wr_data,
    output logic                         mem_rd_en,
    output logic [AW-1:0]                mem_rd_addr,
    output ldq_pkg::step_info_t          info
);

    localparam int LIM_W = (IDX_W > ldq_pkg::CAP_W) ? IDX_W : ldq_pkg::CAP_W;
    localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

    logic [ldq_pkg::CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0]          front_reg, front_next;
    logic [IDX_W-1:0]          rear_reg, rear_next;
    logic [LIM_W-1:0]          cap_ext, limit, rear_ext;
    logic                      empty;
    logic [IDX_W-1:0]          wr_slot, rd_slot;
    logic                      do_wr, do_rd;
    ldq_pkg::status_t          status;
    logic [IDX_W-1:0]          occ_full;

    // Saturate capacity at DEPTH
    assign cap_ext  = LIM_W'(cap_reg);
    assign limit    = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
    assign rear_ext = LIM_W'(rear_reg);
    assign empty    = (front_reg == '0);

    // Decide the operation outcome and next indices
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        status     = ldq_pkg::ST_OK;
        do_wr      = 1'b0;
        do_rd      = 1'b0;
        wr_slot    = rear_reg + ONE;
        rd_slot    = front_reg;
        case (operation)
            ldq_pkg::OP_PUSH_REAR:
            begin
                if (rear_ext >= limit)
                begin
                    status = ldq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    rear_next = rear_reg + ONE;
                    wr_slot   = rear_reg + ONE;
                    do_wr     = 1'b1;
                    if (empty)
                    begin
                        front_next = ONE;
                    end
                end
            end
            ldq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ldq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rd_slot = front_reg;
                    do_rd   = 1'b1;
                    if (front_reg >= rear_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else
                    begin
                        front_next = front_reg + ONE;
                    end
                end
            end
            ldq_pkg::OP_PUSH_FRONT:
            begin
                if (empty)
                begin
                    status = ldq_pkg::ST_EMPTY;
                end
                else if (front_reg == ONE)
                begin
                    status = ldq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    front_next = front_reg - ONE;
                    wr_slot    = front_reg - ONE;
                    do_wr      = 1'b1;
                end
            end
            default:
            begin
                if (empty)
                begin
                    status = ldq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rd_slot = rear_reg;
                    do_rd   = 1'b1;
                    if (rear_reg <= front_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else
                    begin
                        rear_next = rear_reg - ONE;
                    end
                end
            end
        endcase
    end

    // Occupancy after the step
    assign occ_full = (front_next == '0 || rear_next < front_next)
                      ? '0 : (rear_next - front_next + ONE);

    // Slot n lives at RAM address n-1
    assign mem_wr_en   = accept & do_wr;
    assign mem_wr_addr = AW'(wr_slot - ONE);
    assign mem_wr_data = data_in;
    assign mem_rd_en   = accept & do_rd;
    assign mem_rd_addr = AW'(rd_slot - ONE);

    assign info.rd_hit    = do_rd;
    assign info.status    = status;
    assign info.occupancy = ldq_pkg::OCC_W'(occ_full);

    // Hold capacity and indices; advance indices on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= ldq_pkg::CAP_RESET;
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
            end
        end
    end

endmodule

// File: hdl/linear_double_ended_queue.sv
// linear_double_ended_queue: top level of the byte deque.
// Instantiates ldq_ctrl and ldq_ram; depends on ldq_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: operation and
//   data_in. Output channel (out_valid / out_stall) returns one result per
//   request: data_out, status and occupancy after the step.
//   cfg_wr_en / cfg_wr_data write the capacity register; write it only while
//   no request is in flight.
// Timing:
//   After acceptance a result passes the read stage (registered read of the
//   slot RAM) and then the output register, which loads when out_stall
//   allows. One request is accepted every cycle while in_stall is low; the
//   RAM port pair (one write, one read per cycle) sets that rate.
// Reset:
//   rst_n clears the deque to empty and capacity to 8. Slot contents are not
//   cleared; slots are only read after being written.
// Stall:
//   When out_stall holds a result, the RAM read stage keeps the next result
//   and in_stall rises once both stages are full.
module linear_double_ended_queue #(
    parameter int DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ldq_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ldq_pkg::OP_W-1:0]      operation,
    input  logic [ldq_pkg::DATA_W-1:0]    data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ldq_pkg::DATA_W-1:0]    data_out,
    output logic [ldq_pkg::STAT_W-1:0]    status,
    output logic [ldq_pkg::OCC_W-1:0]     occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        accept;
    logic                        mem_wr_en, mem_rd_en;
    logic [AW-1:0]               mem_wr_addr, mem_rd_addr;
    logic [ldq_pkg::DATA_W-1:0]  mem_wr_data, mem_rd_data;
    ldq_pkg::step_info_t         info;

    logic                        pend_valid_reg;
    ldq_pkg::step_info_t         pend_info_reg;
    logic                        pend_move;

    logic                        out_valid_reg;
    logic [ldq_pkg::DATA_W-1:0]  data_out_reg;
    ldq_pkg::status_t            status_reg;
    logic [ldq_pkg::OCC_W-1:0]   occ_reg;

    // Stall input only when both result stages are full and output is blocked
    assign pend_move = pend_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = pend_valid_reg & out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    ldq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .operation   (operation),
        .data_in     (data_in),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .info        (info)
    );

    ldq_ram #(
        .WIDTH (ldq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Read stage: hold result info while the RAM read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_info_reg <= info;
        end
    end

    // Output stage: take the read stage, or drop a result once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            data_out_reg <= pend_info_reg.rd_hit ? mem_rd_data : ldq_pkg::SPACE_BYTE;
            status_reg   <= pend_info_reg.status;
            occ_reg      <= pend_info_reg.occupancy;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule
